>>> hdl/zcst_pkg.sv
package zcst_pkg;

    // Geometry of the record store
    localparam int GROUPS           = 2;
    localparam int CHUNKS_PER_GROUP = 256;
    localparam int CHUNK_W          = $clog2(CHUNKS_PER_GROUP);
    localparam int RECORDS          = GROUPS * CHUNKS_PER_GROUP;
    localparam int ADDR_W           = $clog2(RECORDS);

    localparam logic [7:0] SECTORS_PER_CHUNK = 8'd128;
    localparam logic [7:0] SAT_MAX           = 8'd255;

    // Chunk state codes
    localparam logic [3:0] ST_FREE    = 4'd1;
    localparam logic [3:0] ST_CLOSED  = 4'd2;
    localparam logic [3:0] ST_OPEN    = 4'd4;
    localparam logic [3:0] ST_OFFLINE = 4'd8;

    // Request types
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;
    localparam logic [1:0] REQ_LOAD  = 2'd3;

    // Verdicts
    localparam logic [2:0] V_MEDIA   = 3'd0;
    localparam logic [2:0] V_PREDEF  = 3'd1;
    localparam logic [2:0] V_FORBID  = 3'd2;
    localparam logic [2:0] V_PASS    = 3'd3;
    localparam logic [2:0] V_UPDATED = 3'd4;

    // Status codes
    localparam logic [2:0] S_NONE      = 3'd0;
    localparam logic [2:0] S_NOT_AT_WP = 3'd1;
    localparam logic [2:0] S_WR_FORBID = 3'd2;
    localparam logic [2:0] S_BAD_RESET = 3'd3;
    localparam logic [2:0] S_OFFLINE   = 3'd4;

    // Configuration register indexes
    localparam logic REG_READ_GUARD  = 1'b0;
    localparam logic REG_MULTI_RESET = 1'b1;

    localparam int CFG_ADDR_W = 3;

    typedef struct packed {
        logic [1:0] req_type;
        logic       apply_update;
        logic       group_select;
        logic [7:0] chunk_index;
        logic [7:0] sector_offset;
        logic       reserved_bits_set;
        logic [3:0] load_state;
        logic [7:0] load_write_pointer;
        logic [7:0] load_wear_index;
    } req_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic [2:0] status_code;
        logic [3:0] chunk_state;
        logic [7:0] write_pointer;
        logic [7:0] wear_index;
    } rsp_t;

    typedef struct packed {
        logic [3:0] st;
        logic [7:0] wp;
        logic [7:0] wear;
    } rec_t;

    // Operation decided by the front end
    typedef enum logic [2:0] {
        OP_CHK_READ,
        OP_CHK_WRITE,
        OP_CHK_RESET,
        OP_NOP,
        OP_APPLY_WRITE,
        OP_APPLY_RESET,
        OP_LOAD
    } op_t;

    // Command held in the queue between front and back
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        offset;
        logic              resv;
        rec_t              load_rec;
    } cmd_t;

endpackage

>>> hdl/zcst_front.sv
module zcst_front
(
    input  logic            start,
    input  zcst_pkg::req_t  request,
    input  logic            q_full,
    input  logic            clearing,
    output logic            busy,
    output logic            push,
    output zcst_pkg::cmd_t  cmd
);

    // Requests are refused while the queue is full or the store is being cleared.
    assign busy = q_full || clearing;
    assign push = start && !busy;

    // Classify the request into one back-end operation.
    always_comb
    begin
        cmd.addr          = {request.group_select, request.chunk_index[zcst_pkg::CHUNK_W-1:0]};
        cmd.offset        = request.sector_offset;
        cmd.resv          = request.reserved_bits_set;
        cmd.load_rec.st   = request.load_state;
        cmd.load_rec.wp   = request.load_write_pointer;
        cmd.load_rec.wear = request.load_wear_index;
        case (request.req_type)
            zcst_pkg::REQ_READ:
                cmd.op = request.apply_update ? zcst_pkg::OP_NOP : zcst_pkg::OP_CHK_READ;
            zcst_pkg::REQ_WRITE:
                cmd.op = request.apply_update ? zcst_pkg::OP_APPLY_WRITE
                                              : zcst_pkg::OP_CHK_WRITE;
            zcst_pkg::REQ_RESET:
                cmd.op = request.apply_update ? zcst_pkg::OP_APPLY_RESET
                                              : zcst_pkg::OP_CHK_RESET;
            default:
                cmd.op = zcst_pkg::OP_LOAD;
        endcase
    end

endmodule

>>> hdl/zcst_queue.sv
module zcst_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  zcst_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output zcst_pkg::cmd_t  head,
    output logic            full,
    output logic            empty
);

    zcst_pkg::cmd_t slot_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/zcst_back.sv
module zcst_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  zcst_pkg::cmd_t  head,
    input  logic            q_empty,
    output logic            pop,
    input  logic [6:0]      read_guard,
    input  logic            multi_reset_enable,
    output logic            clearing,
    output logic            done,
    output zcst_pkg::rsp_t  result
);

    typedef enum logic [1:0] {
        CLEAR,
        IDLE,
        EXEC
    } state_t;

    state_t                      state_reg;
    logic [zcst_pkg::ADDR_W-1:0] clr_addr_reg;
    zcst_pkg::cmd_t              cmd_reg;
    logic                        done_reg;
    zcst_pkg::rsp_t              result_reg;

    zcst_pkg::rec_t mem [0:zcst_pkg::RECORDS-1];
    zcst_pkg::rec_t rd_data_reg;

    logic                        mem_we;
    logic [zcst_pkg::ADDR_W-1:0] mem_waddr;
    zcst_pkg::rec_t              mem_wdata;

    zcst_pkg::rec_t rec;
    zcst_pkg::rec_t rec_next;
    logic [2:0]     verdict_next;
    logic [2:0]     status_next;
    logic [7:0]     wp_inc;
    logic [7:0]     wear_inc;
    logic [8:0]     guard_sum;

    assign clearing = (state_reg == CLEAR);
    assign pop      = (state_reg == IDLE) && !q_empty;
    assign done     = done_reg;
    assign result   = result_reg;

    // Record update and verdict for the command being executed.
    always_comb
    begin
        rec          = rd_data_reg;
        rec_next     = rd_data_reg;
        verdict_next = zcst_pkg::V_UPDATED;
        status_next  = zcst_pkg::S_NONE;
        wp_inc       = (rec.wp == zcst_pkg::SAT_MAX) ? rec.wp : rec.wp + 8'd1;
        wear_inc     = (rec.wear == zcst_pkg::SAT_MAX) ? rec.wear : rec.wear + 8'd1;
        guard_sum    = {1'b0, cmd_reg.offset} + {2'b00, read_guard};
        case (cmd_reg.op)
            zcst_pkg::OP_CHK_READ:
            begin
                if ((rec.st == zcst_pkg::ST_OPEN || rec.st == zcst_pkg::ST_CLOSED)
                    && guard_sum < {1'b0, rec.wp})
                begin
                    verdict_next = zcst_pkg::V_MEDIA;
                end
                else
                begin
                    verdict_next = zcst_pkg::V_PREDEF;
                end
            end
            zcst_pkg::OP_CHK_WRITE:
            begin
                verdict_next = zcst_pkg::V_FORBID;
                if (rec.st == zcst_pkg::ST_OPEN && cmd_reg.offset != rec.wp)
                begin
                    status_next = zcst_pkg::S_NOT_AT_WP;
                end
                else if (rec.st == zcst_pkg::ST_CLOSED || rec.st == zcst_pkg::ST_OFFLINE
                         || cmd_reg.resv)
                begin
                    status_next = zcst_pkg::S_WR_FORBID;
                end
                else
                begin
                    verdict_next = zcst_pkg::V_PASS;
                end
            end
            zcst_pkg::OP_CHK_RESET:
            begin
                verdict_next = zcst_pkg::V_FORBID;
                if (!multi_reset_enable && rec.st == zcst_pkg::ST_FREE)
                begin
                    status_next = zcst_pkg::S_BAD_RESET;
                end
                else if (rec.st == zcst_pkg::ST_OFFLINE)
                begin
                    status_next = zcst_pkg::S_OFFLINE;
                end
                else if (rec.st == zcst_pkg::ST_OPEN || cmd_reg.resv)
                begin
                    status_next = zcst_pkg::S_BAD_RESET;
                end
                else
                begin
                    verdict_next = zcst_pkg::V_PASS;
                end
            end
            zcst_pkg::OP_APPLY_WRITE:
            begin
                rec_next.wp = wp_inc;
                if (rec.st == zcst_pkg::ST_FREE)
                begin
                    rec_next.st = zcst_pkg::ST_OPEN;
                end
                else if (rec.st == zcst_pkg::ST_OPEN && wp_inc == zcst_pkg::SECTORS_PER_CHUNK)
                begin
                    rec_next.st = zcst_pkg::ST_CLOSED;
                end
            end
            zcst_pkg::OP_APPLY_RESET:
            begin
                rec_next.wear = wear_inc;
                if (rec.st == zcst_pkg::ST_CLOSED)
                begin
                    if (wear_inc == zcst_pkg::SAT_MAX)
                    begin
                        rec_next.st = zcst_pkg::ST_OFFLINE;
                    end
                    else
                    begin
                        rec_next.st = zcst_pkg::ST_FREE;
                        rec_next.wp = 8'd0;
                    end
                end
            end
            zcst_pkg::OP_LOAD:
            begin
                rec_next = cmd_reg.load_rec;
            end
            default:
            begin
                rec_next = rd_data_reg;
            end
        endcase
    end

    // Write port: the clearing sweep, then write-back of executed commands.
    always_comb
    begin
        mem_we    = (state_reg == CLEAR) || (state_reg == EXEC);
        mem_waddr = (state_reg == CLEAR) ? clr_addr_reg : cmd_reg.addr;
        mem_wdata = (state_reg == CLEAR) ? '0 : rec_next;
    end

    // Record store.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            rd_data_reg <= mem[head.addr];
        end
    end

    // Sequencer: clear, then read one record and execute on it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CLEAR;
            clr_addr_reg <= '0;
            cmd_reg      <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + {{(zcst_pkg::ADDR_W-1){1'b0}}, 1'b1};
                    if (clr_addr_reg == '1)
                    begin
                        state_reg <= IDLE;
                    end
                end
                IDLE:
                begin
                    if (pop)
                    begin
                        cmd_reg   <= head;
                        state_reg <= EXEC;
                    end
                end
                EXEC:
                begin
                    done_reg               <= 1'b1;
                    result_reg.verdict     <= verdict_next;
                    result_reg.status_code <= status_next;
                    result_reg.chunk_state <= rec_next.st;
                    result_reg.write_pointer <= rec_next.wp;
                    result_reg.wear_index  <= rec_next.wear;
                    state_reg              <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/zoned_chunk_state_tracker_top.sv
// Channel     | Ports                               | Transfer
// ------------+-------------------------------------+--------------------------------
// request     | start, busy, request                | edge with start high, busy low
// result      | done, result                        | edge that ends the done cycle
// config      | psel penable pwrite paddr pwdata    | edge with psel, penable, pwrite
//             | prdata pready                       | and pready high
//
// After reset a sweep zeroes every record of the record store; busy stays high
// throughout it. A request waits in a two-entry queue; the back end then reads
// its record, then executes it and writes it back, and takes no new request
// until that is done; done is registered at the execute and write-back. busy
// rises only when the queue is full or the store is being cleared. The
// receiver cannot stall: each result is shown for a single cycle.
module zoned_chunk_state_tracker_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  zcst_pkg::req_t                    request,
    output logic                              done,
    output zcst_pkg::rsp_t                    result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [zcst_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [6:0]     read_guard_reg;
    logic           multi_reset_reg;
    logic           cfg_write;

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    logic           clearing;
    zcst_pkg::cmd_t push_cmd;
    zcst_pkg::cmd_t head;

    // Configuration registers; the register is picked by address bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_guard_reg  <= 7'd0;
            multi_reset_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == zcst_pkg::REG_READ_GUARD)
            begin
                read_guard_reg <= pwdata[6:0];
            end
            else
            begin
                multi_reset_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == zcst_pkg::REG_MULTI_RESET)
        begin
            prdata = {31'd0, multi_reset_reg};
        end
        else
        begin
            prdata = {25'd0, read_guard_reg};
        end
    end

    zcst_front u_front
    (
        .start    (start),
        .request  (request),
        .q_full   (q_full),
        .clearing (clearing),
        .busy     (busy),
        .push     (push),
        .cmd      (push_cmd)
    );

    zcst_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    zcst_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .head               (head),
        .q_empty            (q_empty),
        .pop                (pop),
        .read_guard         (read_guard_reg),
        .multi_reset_enable (multi_reset_reg),
        .clearing           (clearing),
        .done               (done),
        .result             (result)
    );

endmodule

>>> hdl/zcst_checker.sv
module zcst_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           done,
    input zcst_pkg::rsp_t result
);

    // The back end never finishes two requests in consecutive cycles.
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on consecutive cycles");

    // Verdict and status codes stay within their defined sets.
    a_codes_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.verdict <= zcst_pkg::V_UPDATED)
                 && (result.status_code <= zcst_pkg::S_OFFLINE))
        else $error("undefined verdict or status code");

    // A non-zero status comes only with a forbidden verdict.
    a_status_forbid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status_code != zcst_pkg::S_NONE)
            |-> (result.verdict == zcst_pkg::V_FORBID))
        else $error("status without forbidden verdict");

    // A media read is only granted on an open or closed chunk.
    a_media_state: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.verdict == zcst_pkg::V_MEDIA)
            |-> ((result.chunk_state == zcst_pkg::ST_OPEN
                  || result.chunk_state == zcst_pkg::ST_CLOSED)
                 && result.status_code == zcst_pkg::S_NONE))
        else $error("media read on a chunk that is neither open nor closed");

endmodule

bind zoned_chunk_state_tracker_top zcst_checker u_zcst_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .done   (done),
    .result (result)
);

>>> sim/tb_zoned_chunk_state_tracker_top.sv
`timescale 1ns / 100ps

module tb_zoned_chunk_state_tracker_top;

    localparam int CLK_HALF   = 5;
    localparam int CYCLE_CAP  = 200000;
    localparam int SETTLE     = 8;
    localparam int REPORT_MAX = 10;

    // Keeps its own copy of every chunk record and of the two registers, and
    // queues the result that each accepted request must produce.
    class chunk_state_scoreboard;
        zcst_pkg::rec_t records [zcst_pkg::RECORDS];
        logic [6:0]     guard;
        logic           multi_reset;
        zcst_pkg::rsp_t expected_results [$];
        int             mismatches;

        function new();
            foreach (records[i])
                records[i] = '0;
            guard       = '0;
            multi_reset = 1'b0;
            mismatches  = 0;
        endfunction

        function zcst_pkg::rec_t peek(input logic grp, input logic [7:0] chunk);
            return records[{grp, chunk}];
        endfunction

        function void set_register(input logic idx, input logic [31:0] value);
            if (idx == zcst_pkg::REG_READ_GUARD)
                guard = value[6:0];
            else
                multi_reset = value[0];
        endfunction

        // Works out the result of one accepted request and updates the record.
        function void note_request(input zcst_pkg::req_t req);
            logic [zcst_pkg::ADDR_W-1:0] addr;
            zcst_pkg::rec_t              rec;
            zcst_pkg::rsp_t              want;
            logic [8:0]                  reach;

            addr             = {req.group_select, req.chunk_index};
            rec              = records[addr];
            want.verdict     = zcst_pkg::V_UPDATED;
            want.status_code = zcst_pkg::S_NONE;

            if (req.req_type == zcst_pkg::REQ_LOAD)
            begin
                rec.st   = req.load_state;
                rec.wp   = req.load_write_pointer;
                rec.wear = req.load_wear_index;
            end
            else if (req.apply_update)
            begin
                if (req.req_type == zcst_pkg::REQ_WRITE)
                begin
                    if (rec.wp != zcst_pkg::SAT_MAX)
                        rec.wp = rec.wp + 8'd1;
                    if (rec.st == zcst_pkg::ST_FREE)
                        rec.st = zcst_pkg::ST_OPEN;
                    else if (rec.st == zcst_pkg::ST_OPEN
                             && rec.wp == zcst_pkg::SECTORS_PER_CHUNK)
                        rec.st = zcst_pkg::ST_CLOSED;
                end
                else if (req.req_type == zcst_pkg::REQ_RESET)
                begin
                    if (rec.wear != zcst_pkg::SAT_MAX)
                        rec.wear = rec.wear + 8'd1;
                    if (rec.st == zcst_pkg::ST_CLOSED)
                    begin
                        if (rec.wear == zcst_pkg::SAT_MAX)
                            rec.st = zcst_pkg::ST_OFFLINE;
                        else
                        begin
                            rec.st = zcst_pkg::ST_FREE;
                            rec.wp = '0;
                        end
                    end
                end
            end
            else if (req.req_type == zcst_pkg::REQ_READ)
            begin
                // The guard is added to the offset, so nothing can underflow.
                reach = {1'b0, req.sector_offset} + {2'b00, guard};
                if ((rec.st == zcst_pkg::ST_OPEN || rec.st == zcst_pkg::ST_CLOSED)
                    && reach < {1'b0, rec.wp})
                    want.verdict = zcst_pkg::V_MEDIA;
                else
                    want.verdict = zcst_pkg::V_PREDEF;
            end
            else if (req.req_type == zcst_pkg::REQ_WRITE)
            begin
                want.verdict = zcst_pkg::V_FORBID;
                if (rec.st == zcst_pkg::ST_OPEN && req.sector_offset != rec.wp)
                    want.status_code = zcst_pkg::S_NOT_AT_WP;
                else if (rec.st == zcst_pkg::ST_CLOSED || rec.st == zcst_pkg::ST_OFFLINE
                         || req.reserved_bits_set)
                    want.status_code = zcst_pkg::S_WR_FORBID;
                else
                    want.verdict = zcst_pkg::V_PASS;
            end
            else
            begin
                want.verdict = zcst_pkg::V_FORBID;
                if (!multi_reset && rec.st == zcst_pkg::ST_FREE)
                    want.status_code = zcst_pkg::S_BAD_RESET;
                else if (rec.st == zcst_pkg::ST_OFFLINE)
                    want.status_code = zcst_pkg::S_OFFLINE;
                else if (rec.st == zcst_pkg::ST_OPEN || req.reserved_bits_set)
                    want.status_code = zcst_pkg::S_BAD_RESET;
                else
                    want.verdict = zcst_pkg::V_PASS;
            end

            records[addr]      = rec;
            want.chunk_state   = rec.st;
            want.write_pointer = rec.wp;
            want.wear_index    = rec.wear;
            expected_results.push_back(want);
        endfunction

        // Compares one result transfer with the oldest expectation.
        function void check_result(input zcst_pkg::rsp_t got);
            zcst_pkg::rsp_t want;

            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with nothing expected: %p", $realtime, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.verdict !== want.verdict || got.status_code !== want.status_code ||
                got.chunk_state !== want.chunk_state ||
                got.write_pointer !== want.write_pointer ||
                got.wear_index !== want.wear_index)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result mismatch: expected %p, got %p",
                             $realtime, want, got);
            end
        endfunction
    endclass

    logic                            clk     = 1'b0;
    logic                            rst_n   = 1'b0;
    logic                            start   = 1'b0;
    logic                            busy;
    zcst_pkg::req_t                  request = '0;
    logic                            done;
    zcst_pkg::rsp_t                  result;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [zcst_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]                     pwdata  = '0;
    logic [31:0]                     prdata;
    logic                            pready;
    int                              cycles  = 0;

    chunk_state_scoreboard sb = new();

    zoned_chunk_state_tracker_top u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF clk = ~clk;

    // Results are accepted at the edge that ends the done cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP)
        begin
            $display("FAIL zoned_chunk_state_tracker_top");
            $finish;
        end
    end

    // One register write: a setup phase, an access phase held until pready,
    // then the bus goes idle.
    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] guard_word, input logic [31:0] multi_word);
        write_register(zcst_pkg::REG_READ_GUARD, guard_word);
        write_register(zcst_pkg::REG_MULTI_RESET, multi_word);
    endtask

    // Offers one request, with a random idle stretch in front of it, and waits
    // for the transfer.
    task automatic send_request(input zcst_pkg::req_t item, input int idle_pct);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(item);
    endtask

    // Waits until every expected result has arrived and the pipeline is empty.
    task automatic drain();
        start <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic zcst_pkg::req_t make_request(input logic [1:0] kind, input logic apply,
                                                    input logic grp, input logic [7:0] chunk,
                                                    input logic [7:0] offset, input logic resv,
                                                    input logic [3:0] ld_st,
                                                    input logic [7:0] ld_wp,
                                                    input logic [7:0] ld_wear);
        zcst_pkg::req_t r;

        r.req_type           = kind;
        r.apply_update       = apply;
        r.group_select       = grp;
        r.chunk_index        = chunk;
        r.sector_offset      = offset;
        r.reserved_bits_set  = resv;
        r.load_state         = ld_st;
        r.load_write_pointer = ld_wp;
        r.load_wear_index    = ld_wear;
        return r;
    endfunction

    // Edge cases: empty records, pointer checks, fill to closed, wear-out to
    // offline, reset of a free chunk, saturation and unknown state codes.
    task automatic run_directed();
        send_request(make_request(zcst_pkg::REQ_READ,  1'b0, 1'b0, 8'd0,   8'd0,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_WRITE, 1'b0, 1'b0, 8'd0,   8'd255, 1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_WRITE, 1'b0, 1'b0, 8'd0,   8'd0,   1'b1,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_LOAD,  1'b0, 1'b1, 8'd255, 8'd0,   1'b0,
                                  zcst_pkg::ST_OPEN, 8'd5, 8'd0), 0);
        send_request(make_request(zcst_pkg::REQ_WRITE, 1'b0, 1'b1, 8'd255, 8'd5,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_WRITE, 1'b0, 1'b1, 8'd255, 8'd6,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_WRITE, 1'b1, 1'b1, 8'd255, 8'd0,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_READ,  1'b0, 1'b1, 8'd255, 8'd0,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_READ,  1'b0, 1'b1, 8'd255, 8'd255, 1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_LOAD,  1'b1, 1'b1, 8'd255, 8'd0,   1'b0,
                                  zcst_pkg::ST_OPEN, 8'd127, 8'd254), 0);
        send_request(make_request(zcst_pkg::REQ_WRITE, 1'b1, 1'b1, 8'd255, 8'd127, 1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_RESET, 1'b0, 1'b1, 8'd255, 8'd0,   1'b1,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_RESET, 1'b0, 1'b1, 8'd255, 8'd0,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_RESET, 1'b1, 1'b1, 8'd255, 8'd0,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_RESET, 1'b0, 1'b1, 8'd255, 8'd0,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_WRITE, 1'b0, 1'b1, 8'd255, 8'd128, 1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_LOAD,  1'b0, 1'b0, 8'd128, 8'd0,   1'b0,
                                  zcst_pkg::ST_CLOSED, 8'd200, 8'd0), 0);
        send_request(make_request(zcst_pkg::REQ_RESET, 1'b1, 1'b0, 8'd128, 8'd0,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_RESET, 1'b0, 1'b0, 8'd128, 8'd0,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_WRITE, 1'b1, 1'b0, 8'd128, 8'd0,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_RESET, 1'b0, 1'b0, 8'd128, 8'd1,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_LOAD,  1'b1, 1'b0, 8'd128, 8'd0,   1'b0,
                                  4'hF, 8'd255, 8'd255), 0);
        send_request(make_request(zcst_pkg::REQ_WRITE, 1'b1, 1'b0, 8'd128, 8'd0,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_RESET, 1'b1, 1'b0, 8'd128, 8'd0,   1'b0,
                                  '0, '0, '0), 0);
        send_request(make_request(zcst_pkg::REQ_READ,  1'b1, 1'b0, 8'd128, 8'd0,   1'b0,
                                  '0, '0, '0), 0);
    endtask

    // Random request aimed mostly at a few hot chunks so that records run
    // through their whole life; offsets usually follow the pointer.
    function automatic zcst_pkg::req_t random_request();
        zcst_pkg::req_t r;
        zcst_pkg::rec_t rec;
        logic [63:0]    noise;
        int             pick;

        noise = {$urandom, $urandom};
        r     = noise[$bits(zcst_pkg::req_t)-1:0];
        r.reserved_bits_set = ($urandom_range(9) == 0);
        if ($urandom_range(4) != 0)
            r.chunk_index = 8'($urandom_range(7));
        rec  = sb.peek(r.group_select, r.chunk_index);
        pick = $urandom_range(99);

        if (pick < 12)
        begin
            r.req_type = zcst_pkg::REQ_LOAD;
            case ($urandom_range(5))
                0: r.load_state = zcst_pkg::ST_FREE;
                1: r.load_state = zcst_pkg::ST_CLOSED;
                2: r.load_state = zcst_pkg::ST_OPEN;
                3: r.load_state = zcst_pkg::ST_OFFLINE;
                default: ;
            endcase
            if ($urandom_range(1) == 0)
                r.load_write_pointer = 8'($urandom_range(127, 118));
            if ($urandom_range(1) == 0)
                r.load_wear_index = 8'($urandom_range(255, 250));
        end
        else if (pick < 55)
        begin
            r.req_type     = zcst_pkg::REQ_WRITE;
            r.apply_update = (pick < 40);
            if ($urandom_range(9) < 7)
                r.sector_offset = rec.wp;
        end
        else if (pick < 80)
        begin
            r.req_type     = zcst_pkg::REQ_RESET;
            r.apply_update = (pick < 68);
        end
        else
        begin
            r.req_type = zcst_pkg::REQ_READ;
            r.apply_update = ($urandom_range(4) == 0);
            if ($urandom_range(1) == 0)
                r.sector_offset = rec.wp - {1'b0, sb.guard} - 8'd2 + 8'($urandom_range(2));
        end
        return r;
    endfunction

    task automatic run_random(input int count, input int idle_pct);
        repeat (count) send_request(random_request(), idle_pct);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The store is swept clear after reset; busy is high until it is done.
        do
            @(posedge clk);
        while (busy);

        set_config(32'd0, 32'd0);
        run_directed();
        drain();

        set_config(32'd127, 32'd1);
        run_random(215, 0);
        drain();

        set_config(32'($urandom_range(127)), 32'd0);
        run_random(215, 66);
        drain();

        // Upper bits of the register words must be ignored.
        set_config($urandom, $urandom | 32'd1);
        run_random(210, 0);
        drain();

        set_config(32'($urandom_range(8)), 32'd0);
        run_random(210, 17);
        drain();

        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("PASS zoned_chunk_state_tracker_top");
        else
            $display("FAIL zoned_chunk_state_tracker_top");
        $finish;
    end

endmodule
